@@ design/imh_pkg.sv @@
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants
// Key sentinel, operation codes, command and status structs, controller states.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int unsigned KEY_W = 20;
    localparam int unsigned ELEM_W = 10;
    localparam logic [KEY_W-1:0] SENTINEL_KEY = 20'd1000000;

    localparam logic OP_SET = 1'b0;
    localparam logic OP_POP = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WRITE,
        ST_DN_READ,
        ST_DN_CMP,
        ST_UP_READ,
        ST_UP_CMP,
        ST_TOP_READ,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic lookup;
        logic write_key;
        logic dn_read;
        logic dn_swap;
        logic up_read;
        logic up_swap;
        logic top_read;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic skip_item;
        logic dn_has_child;
        logic dn_swap_ok;
        logic up_at_root;
        logic up_swap_ok;
    } status_t;

endpackage

@@ design/indexed_min_heap.sv @@
// ----------------------------------------------------------------------------
// indexed_min_heap: indexed binary min-heap priority queue
// Set key or pop minimum per item; each item returns the heap minimum.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all ENTRIES slots with s_ready
// low. An item then occupies the block until its result is loaded; the time
// grows with the heap levels that it moves down and up, as the single sift
// sequencer does one heap level per read/compare pair on the memories.
// The result sits in an output register, so the next item is taken while it
// waits.
module indexed_min_heap #(
    parameter int unsigned ENTRIES = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic [imh_pkg::ELEM_W-1:0]   s_element,
    input  logic [imh_pkg::KEY_W-1:0]    s_new_key,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [imh_pkg::KEY_W-1:0]    m_min_key,
    output logic [imh_pkg::ELEM_W-1:0]   m_min_element
);

    imh_pkg::cmd_t    cmd;
    imh_pkg::status_t status;

    imh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    imh_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .in_operation (s_operation),
        .in_element   (s_element),
        .in_new_key   (s_new_key),
        .res_key      (m_min_key),
        .res_element  (m_min_element)
    );

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_min_key))
        else $error("result dropped while stalled");

    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_min_key <= imh_pkg::SENTINEL_KEY)
        else $error("min key above sentinel");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.dn_swap, cmd.up_swap, cmd.write_key, cmd.clear_step}))
        else $error("conflicting memory writes");

endmodule

@@ design/imh_datapath.sv @@
// ----------------------------------------------------------------------------
// imh_datapath: heap memories and sift datapath
// Holds keys and both index maps, walks one heap level per read/compare pair.
// ----------------------------------------------------------------------------
module imh_datapath #(
    parameter int unsigned ENTRIES = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  imh_pkg::cmd_t                cmd,
    output imh_pkg::status_t             status,
    input  logic                         in_operation,
    input  logic [imh_pkg::ELEM_W-1:0]   in_element,
    input  logic [imh_pkg::KEY_W-1:0]    in_new_key,
    output logic [imh_pkg::KEY_W-1:0]    res_key,
    output logic [imh_pkg::ELEM_W-1:0]   res_element
);

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned PW = AW + 1;
    localparam int unsigned EW = imh_pkg::ELEM_W;
    localparam int unsigned KW = imh_pkg::KEY_W;

    logic [KW-1:0] key_mem [ENTRIES];
    logic [AW-1:0] pos_mem [ENTRIES];
    logic [AW-1:0] elem_mem [ENTRIES];

    logic [AW-1:0] clr_reg, clr_next;
    logic          op_reg;
    logic [EW-1:0] elem_in_reg;
    logic [KW-1:0] key_in_reg;
    logic [AW-1:0] pos_reg;
    logic [KW-1:0] cur_key_reg;
    logic [AW-1:0] cur_elem_reg;
    logic [KW-1:0] ka_reg, kb_reg;
    logic [AW-1:0] ea_reg, eb_reg;
    logic [AW-1:0] na_reg;
    logic          has_b_reg;
    logic [KW-1:0] res_key_reg;
    logic [EW-1:0] res_elem_reg;

    logic [PW-1:0] child_l, child_r;
    logic [AW-1:0] parent;
    logic          pick_b;
    logic [KW-1:0] ck;
    logic [AW-1:0] ce, cp;
    logic [KW-1:0] sat_key;

    assign child_l = {pos_reg, 1'b1};
    assign child_r = child_l + PW'(1);
    assign parent = AW'((PW'(pos_reg) - PW'(1)) >> 1);
    assign pick_b = has_b_reg && (kb_reg < ka_reg);
    assign ck = pick_b ? kb_reg : ka_reg;
    assign ce = pick_b ? eb_reg : ea_reg;
    assign cp = pick_b ? AW'(na_reg + AW'(1)) : na_reg;
    assign sat_key = (in_new_key > imh_pkg::SENTINEL_KEY) ? imh_pkg::SENTINEL_KEY : in_new_key;

    assign clr_next = clr_reg + AW'(1);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_reg <= clr_next;
        end
    end
    assign status.clear_done = (clr_reg == AW'(ENTRIES - 1));
    assign status.skip_item = (op_reg == imh_pkg::OP_SET) && (32'(elem_in_reg) >= ENTRIES);
    assign status.dn_has_child = (32'(child_l) < ENTRIES);
    assign status.dn_swap_ok = ck < cur_key_reg;
    assign status.up_at_root = (pos_reg == '0);
    assign status.up_swap_ok = cur_key_reg < ka_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            key_mem[clr_reg] <= imh_pkg::SENTINEL_KEY;
            pos_mem[clr_reg] <= clr_reg;
            elem_mem[clr_reg] <= clr_reg;
        end
        if (cmd.load_item) begin
            op_reg <= in_operation;
            elem_in_reg <= in_element;
            key_in_reg <= (in_operation == imh_pkg::OP_POP) ? imh_pkg::SENTINEL_KEY : sat_key;
        end
        if (cmd.lookup) begin
            if (op_reg == imh_pkg::OP_POP) begin
                pos_reg <= '0;
                cur_elem_reg <= elem_mem[0];
            end else begin
                pos_reg <= pos_mem[AW'(elem_in_reg)];
                cur_elem_reg <= AW'(elem_in_reg);
            end
        end
        if (cmd.write_key) begin
            key_mem[pos_reg] <= key_in_reg;
            cur_key_reg <= key_in_reg;
        end
        if (cmd.dn_read) begin
            na_reg <= AW'(child_l);
            ka_reg <= key_mem[AW'(child_l)];
            ea_reg <= elem_mem[AW'(child_l)];
            has_b_reg <= 32'(child_r) < ENTRIES;
            kb_reg <= key_mem[AW'(child_r)];
            eb_reg <= elem_mem[AW'(child_r)];
        end
        if (cmd.dn_swap) begin
            key_mem[pos_reg] <= ck;
            elem_mem[pos_reg] <= ce;
            pos_mem[ce] <= pos_reg;
            key_mem[cp] <= cur_key_reg;
            elem_mem[cp] <= cur_elem_reg;
            pos_mem[cur_elem_reg] <= cp;
            pos_reg <= cp;
        end
        if (cmd.up_read) begin
            na_reg <= parent;
            ka_reg <= key_mem[parent];
            ea_reg <= elem_mem[parent];
        end
        if (cmd.up_swap) begin
            key_mem[pos_reg] <= ka_reg;
            elem_mem[pos_reg] <= ea_reg;
            pos_mem[ea_reg] <= pos_reg;
            key_mem[na_reg] <= cur_key_reg;
            elem_mem[na_reg] <= cur_elem_reg;
            pos_mem[cur_elem_reg] <= na_reg;
            pos_reg <= na_reg;
        end
        if (cmd.top_read) begin
            ka_reg <= key_mem[0];
            ea_reg <= elem_mem[0];
        end
        if (cmd.load_result) begin
            res_key_reg <= ka_reg;
            res_elem_reg <= EW'(ea_reg);
        end
    end

    assign res_key = res_key_reg;
    assign res_element = res_elem_reg;

endmodule

@@ design/imh_ctrl.sv @@
// ----------------------------------------------------------------------------
// imh_ctrl: sequencer for the heap
// Runs the clearing pass, then per item: lookup, write, sift down, sift up, result.
// ----------------------------------------------------------------------------
module imh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output imh_pkg::cmd_t     cmd,
    input  imh_pkg::status_t  status
);

    imh_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= imh_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign s_ready = (state_reg == imh_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            imh_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_done) state_next = imh_pkg::ST_IDLE;
            end
            imh_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next = imh_pkg::ST_LOOKUP;
                end
            end
            imh_pkg::ST_LOOKUP: begin
                if (status.skip_item) begin
                    state_next = imh_pkg::ST_TOP_READ;
                end else begin
                    cmd.lookup = 1'b1;
                    state_next = imh_pkg::ST_WRITE;
                end
            end
            imh_pkg::ST_WRITE: begin
                cmd.write_key = 1'b1;
                state_next = imh_pkg::ST_DN_READ;
            end
            imh_pkg::ST_DN_READ: begin
                if (status.dn_has_child) begin
                    cmd.dn_read = 1'b1;
                    state_next = imh_pkg::ST_DN_CMP;
                end else begin
                    state_next = imh_pkg::ST_UP_READ;
                end
            end
            imh_pkg::ST_DN_CMP: begin
                if (status.dn_swap_ok) begin
                    cmd.dn_swap = 1'b1;
                    state_next = imh_pkg::ST_DN_READ;
                end else begin
                    state_next = imh_pkg::ST_UP_READ;
                end
            end
            imh_pkg::ST_UP_READ: begin
                if (status.up_at_root) begin
                    state_next = imh_pkg::ST_TOP_READ;
                end else begin
                    cmd.up_read = 1'b1;
                    state_next = imh_pkg::ST_UP_CMP;
                end
            end
            imh_pkg::ST_UP_CMP: begin
                if (status.up_swap_ok) begin
                    cmd.up_swap = 1'b1;
                    state_next = imh_pkg::ST_UP_READ;
                end else begin
                    state_next = imh_pkg::ST_TOP_READ;
                end
            end
            imh_pkg::ST_TOP_READ: begin
                cmd.top_read = 1'b1;
                state_next = imh_pkg::ST_RESULT;
            end
            imh_pkg::ST_RESULT: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.load_result = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = imh_pkg::ST_IDLE;
                end
            end
            default: state_next = imh_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ tb/imh_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_checker: heap model and result checker
// Keeps its own indexed min-heap, updated on each accepted input item, and
// compares every accepted result with the oldest predicted minimum.
// ----------------------------------------------------------------------------
module imh_checker #(
    parameter int unsigned ENTRIES = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         s_operation,
    input  logic [imh_pkg::ELEM_W-1:0]   s_element,
    input  logic [imh_pkg::KEY_W-1:0]    s_new_key,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [imh_pkg::KEY_W-1:0]    m_min_key,
    input  logic [imh_pkg::ELEM_W-1:0]   m_min_element,
    output int                           fail_count,
    output int                           pending_mins
);

    typedef struct packed {
        logic [imh_pkg::KEY_W-1:0]  key;
        logic [imh_pkg::ELEM_W-1:0] elem;
    } heap_min_t;

    logic [imh_pkg::KEY_W-1:0] heap_key [ENTRIES];
    int unsigned               pos_of   [ENTRIES];
    int unsigned               elem_at  [ENTRIES];
    heap_min_t                 min_queue[$];

    function automatic void exchange(int unsigned p, int unsigned q);
        logic [imh_pkg::KEY_W-1:0] k;
        int unsigned               ep;
        int unsigned               eq;
        k = heap_key[p];
        ep = elem_at[p];
        eq = elem_at[q];
        heap_key[p] = heap_key[q];
        heap_key[q] = k;
        elem_at[p] = eq;
        elem_at[q] = ep;
        pos_of[eq] = p;
        pos_of[ep] = q;
    endfunction

    function automatic void rekey(int unsigned e, logic [imh_pkg::KEY_W-1:0] k);
        int unsigned p;
        int unsigned c;
        p = pos_of[e];
        heap_key[p] = k;
        while (2 * p + 1 < ENTRIES) begin
            c = 2 * p + 1;
            if (c + 1 < ENTRIES && heap_key[c+1] < heap_key[c]) c = c + 1;
            if (heap_key[c] < heap_key[p]) begin
                exchange(p, c);
                p = c;
            end else break;
        end
        while (p > 0) begin
            c = (p - 1) / 2;
            if (heap_key[p] < heap_key[c]) begin
                exchange(p, c);
                p = c;
            end else break;
        end
    endfunction

    function automatic heap_min_t apply_item(logic op, logic [imh_pkg::ELEM_W-1:0] e,
                                             logic [imh_pkg::KEY_W-1:0] k);
        heap_min_t r;
        if (k > imh_pkg::SENTINEL_KEY) k = imh_pkg::SENTINEL_KEY;
        if (op != imh_pkg::OP_SET) rekey(elem_at[0], imh_pkg::SENTINEL_KEY);
        else if (32'(e) < ENTRIES) rekey(32'(e), k);
        r.key = heap_key[0];
        r.elem = imh_pkg::ELEM_W'(elem_at[0]);
        return r;
    endfunction

    always @(posedge aclk) begin
        heap_min_t want;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                heap_key[i] = imh_pkg::SENTINEL_KEY;
                pos_of[i] = i;
                elem_at[i] = i;
            end
            min_queue.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (min_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result key=%0d elem=%0d",
                                 $time, m_min_key, m_min_element);
                end else begin
                    want = min_queue.pop_front();
                    if (want.key !== m_min_key || want.elem !== m_min_element) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: min mismatch exp key=%0d elem=%0d %s%0d elem=%0d",
                                     $time, want.key, want.elem, "got key=",
                                     m_min_key, m_min_element);
                    end
                end
            end
            if (s_valid && s_ready)
                min_queue.push_back(apply_item(s_operation, s_element, s_new_key));
        end
        pending_mins = min_queue.size();
    end
endmodule

@@ tb/tb_indexed_min_heap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_min_heap: indexed min-heap testbench
// Drives directed and random set-key and pop items with random gaps and
// back-pressure, including a long receiver hold-off; the checker predicts
// every minimum.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap;

    localparam int unsigned ENTRIES = 1024;
    localparam int unsigned EW = imh_pkg::ELEM_W;
    localparam int unsigned KW = imh_pkg::KEY_W;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_operation = imh_pkg::OP_SET;
    logic [EW-1:0]     s_element = '0;
    logic [KW-1:0]     s_new_key = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [KW-1:0]     m_min_key;
    logic [EW-1:0]     m_min_element;
    int                fail_count;
    int                pending_mins;
    int                item_count = 0;
    bit                calm = 1'b0;
    bit                hold_sink = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    indexed_min_heap #(.ENTRIES(ENTRIES)) u_dut (.*);

    imh_checker #(.ENTRIES(ENTRIES)) u_checker (.*);

    task automatic send_item(logic op, logic [EW-1:0] e, logic [KW-1:0] k);
        while (!calm && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_element <= e;
        s_new_key <= k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        item_count++;
    endtask

    function automatic logic [KW-1:0] rand_key();
        case ($urandom_range(9))
            0: return KW'($urandom_range(20'hFFFFF, 1000001));
            1: return imh_pkg::SENTINEL_KEY;
            2: return KW'($urandom_range(15));
            default: return KW'($urandom_range(999999));
        endcase
    endfunction

    // receiver
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_ready <= !hold_sink && (calm || $urandom_range(99) >= 37);
        end
    end

    // long receiver hold-off
    initial begin
        @(posedge aresetn);
        wait (item_count >= 400);
        @(negedge aclk);
        hold_sink = 1'b1;
        repeat (600) @(negedge aclk);
        hold_sink = 1'b0;
    end

    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int n;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_item(imh_pkg::OP_POP, EW'(0), KW'(0));
        send_item(imh_pkg::OP_SET, EW'(5), KW'(100));
        send_item(imh_pkg::OP_SET, 10'h3FF, KW'(0));
        send_item(imh_pkg::OP_SET, EW'(7), KW'(0));
        send_item(imh_pkg::OP_SET, EW'(8), 20'hFFFFF);
        send_item(imh_pkg::OP_SET, EW'(9), KW'(1000001));
        send_item(imh_pkg::OP_SET, EW'(5), KW'(0));
        send_item(imh_pkg::OP_SET, EW'(3), KW'(50));
        send_item(imh_pkg::OP_SET, EW'(2), KW'(50));
        send_item(imh_pkg::OP_SET, 10'h3FF, imh_pkg::SENTINEL_KEY);
        send_item(imh_pkg::OP_SET, EW'(0), KW'(999999));
        send_item(imh_pkg::OP_SET, 10'h2AA, 20'h55555);
        send_item(imh_pkg::OP_SET, 10'h155, 20'hAAAAA);
        repeat (6) send_item(imh_pkg::OP_POP, EW'($urandom), KW'($urandom));
        for (n = 0; n < 1150; n++) begin
            calm = (n >= 200 && n < 350);
            if ($urandom_range(3) == 0)
                send_item(imh_pkg::OP_POP, EW'($urandom), KW'($urandom));
            else if ($urandom_range(1))
                send_item(imh_pkg::OP_SET, EW'($urandom_range(31)), rand_key());
            else send_item(imh_pkg::OP_SET, EW'($urandom), rand_key());
        end
        s_valid <= 1'b0;
        calm = 1'b1;
        wait (pending_mins == 0 && !hold_sink);
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending_mins == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ filelist.f @@
design/imh_pkg.sv
design/imh_datapath.sv
design/imh_ctrl.sv
design/indexed_min_heap.sv
tb/imh_checker.sv
tb/tb_indexed_min_heap.sv
